/* rtl/core/lbpg_pkg.sv */
// ----------------------------------------------------------------------------
// LED breathing pulse generator package
// Widths, codes and reset values shared by the pulse generator and its
// checker.
// ----------------------------------------------------------------------------
package lbpg_pkg;

  // Brightness at the top of the envelope.
  localparam int unsigned LEVEL_MAX = 255;

  // Field widths of a command and a result.
  localparam int unsigned COLOR_W    = 2;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned REP_W      = 8;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned M_TDATA_W  = 32;

  // Configuration port.
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned CFG_W      = 8;
  localparam logic [CFG_W-1:0] STEP_PERIOD_RST = 8'd10;
  localparam logic [CFG_W-1:0] MIN_STEPS_RST   = 8'd10;

  // Register indexes, taken from paddr bit 2.
  localparam logic REG_STEP_PERIOD = 1'b0;
  localparam logic REG_MIN_STEPS   = 1'b1;

  // Commands carried on tuser.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Colour codes.
  localparam logic [COLOR_W-1:0] COLOR_RED   = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_GREEN = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_BLUE  = 2'd2;
  localparam logic [COLOR_W-1:0] COLOR_OFF   = 2'd3;

  // Step counter and divider sizing.
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned HALF_W   = STEP_W - 1;
  localparam int unsigned LVLQ_W   = $clog2(LEVEL_MAX + 1);
  localparam int unsigned PROD_W   = STEP_W + LVLQ_W;
  localparam int unsigned TQ_ITER  = LVLQ_W + 1;
  localparam int unsigned SQ_ITER  = DUR_W + 1;
  localparam int unsigned DQ_W     = (SQ_ITER > TQ_ITER) ? SQ_ITER : TQ_ITER;
  localparam int unsigned DIVR_W   = HALF_W;
  localparam int unsigned CNT_W    = $clog2(DQ_W + 1);

endpackage

/* rtl/core/led_breathing_pulse_generator.sv */
// ----------------------------------------------------------------------------
// LED breathing pulse generator
// Triangle brightness envelope for one channel of an RGB LED, driven by
// start and tick commands, with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
// Steps: a start runs the divider for the step count, a tick that advances the
// envelope runs it for a level, and any other command goes straight to its result.
// Throughput: one command at a time; the shared divider retires one quotient
// bit per cycle (17 bits for the step count, 9 bits for a level).
// Reset: asynchronous and active low; it clears the pulse state and the
// levels, and loads both configuration registers with 10.
module led_breathing_pulse_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration port.
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [lbpg_pkg::PADDR_W-1:0]     paddr_i,
  input  logic [lbpg_pkg::PDATA_W-1:0]     pwdata_i,
  output logic [lbpg_pkg::PDATA_W-1:0]     prdata_o,
  output logic                             pready_o,
  // Command stream.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // color [1:0], duration [17:2], repeat_count [25:18], zero [31:26]
  input  logic [lbpg_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // command [0]
  input  logic                             s_axis_tuser_i,
  // Result stream.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // red_level [7:0], green_level [15:8], blue_level [23:16], active [24],
  // start_accepted [25], zero [31:26]
  output logic [lbpg_pkg::M_TDATA_W-1:0]   m_axis_tdata_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam int unsigned STEP_W  = lbpg_pkg::STEP_W;
  localparam int unsigned HALF_W  = lbpg_pkg::HALF_W;
  localparam int unsigned LEVEL_W = lbpg_pkg::LEVEL_W;
  localparam int unsigned DQ_W    = lbpg_pkg::DQ_W;
  localparam int unsigned DIVR_W  = lbpg_pkg::DIVR_W;
  localparam int unsigned CNT_W   = lbpg_pkg::CNT_W;
  localparam int unsigned PROD_W  = lbpg_pkg::PROD_W;
  localparam int unsigned CFG_W   = lbpg_pkg::CFG_W;
  localparam int unsigned COLOR_W = lbpg_pkg::COLOR_W;
  localparam int unsigned REP_W   = lbpg_pkg::REP_W;
  localparam int unsigned DUR_W   = lbpg_pkg::DUR_W;

  // Configuration registers.
  logic [CFG_W-1:0] step_period_q, min_steps_q;
  logic             cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_period_q <= lbpg_pkg::STEP_PERIOD_RST;
      min_steps_q   <= lbpg_pkg::MIN_STEPS_RST;
    end else if (cfg_wr) begin
      unique case (paddr_i[2])
        lbpg_pkg::REG_STEP_PERIOD: step_period_q <= pwdata_i[CFG_W-1:0];
        lbpg_pkg::REG_MIN_STEPS:   min_steps_q   <= pwdata_i[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign prdata_o = (paddr_i[2] == lbpg_pkg::REG_MIN_STEPS) ?
                    lbpg_pkg::PDATA_W'(min_steps_q) :
                    lbpg_pkg::PDATA_W'(step_period_q);

  // Pulse state.
  logic [1:0]         state_q, state_d;
  logic [1:0]         op_q, op_d;
  logic               running_q, running_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic [STEP_W-1:0]  idx_q, idx_d;
  logic [STEP_W-1:0]  spp_q, spp_d;
  logic [REP_W-1:0]   reps_q, reps_d;
  logic [LEVEL_W-1:0] lvl_q [3];
  logic [LEVEL_W-1:0] lvl_d [3];

  // Captured start fields.
  logic [COLOR_W-1:0] new_color_q, new_color_d;
  logic [REP_W-1:0]   new_reps_q, new_reps_d;

  // Divider.
  logic [DIVR_W-1:0]  rem_q, rem_d;
  logic [DIVR_W-1:0]  div_q, div_d;
  logic [DQ_W-1:0]    dq_q, dq_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // Output register.
  logic                                 m_valid_q, m_valid_d;
  logic [lbpg_pkg::M_TDATA_W-1:0]       m_data_q, m_data_d;

  // Incoming fields.
  logic               in_cmd;
  logic [COLOR_W-1:0] in_color;
  logic [DUR_W-1:0]   in_dur;
  logic [REP_W-1:0]   in_reps;
  logic               accept;

  assign in_cmd   = s_axis_tuser_i;
  assign in_color = s_axis_tdata_i[COLOR_W-1:0];
  assign in_dur   = s_axis_tdata_i[COLOR_W+DUR_W-1:COLOR_W];
  assign in_reps  = s_axis_tdata_i[COLOR_W+DUR_W+REP_W-1:COLOR_W+DUR_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Start setup: ceiling division of the duration by twice the period.
  logic [CFG_W-1:0]   period_eff, floor_eff;
  logic [CFG_W:0]     twice;
  logic [DUR_W:0]     ceil_num;

  assign period_eff = (step_period_q == '0) ? CFG_W'(1) : step_period_q;
  assign floor_eff  = (min_steps_q < CFG_W'(2)) ? CFG_W'(2) : min_steps_q;
  assign twice      = {period_eff, 1'b0};
  assign ceil_num   = (DUR_W+1)'(in_dur) + (DUR_W+1)'(twice) - (DUR_W+1)'(1);

  // Tick setup: distance from the nearer end of the pulse, scaled by the peak.
  logic [HALF_W-1:0]  half;
  logic [STEP_W-1:0]  num;
  logic [PROD_W-1:0]  prod;

  assign half = spp_q[STEP_W-1:1];
  always_comb begin
    if (idx_q < STEP_W'(half)) begin
      num = idx_q;
    end else if (spp_q >= idx_q) begin
      num = spp_q - idx_q;
    end else begin
      num = '0;
    end
  end
  assign prod = PROD_W'(num) * PROD_W'(lbpg_pkg::LEVEL_MAX);

  // One restoring step.
  logic [DIVR_W:0]    trial, diff;
  logic               fits;

  assign trial = {rem_q, dq_q[DQ_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = (trial >= {1'b0, div_q});

  // Finishing values.
  logic [DQ_W-1:0]    steps_raw;
  logic [STEP_W-1:0]  idx_inc;
  logic [LEVEL_W-1:0] lvl_sat;
  logic               out_free;

  assign steps_raw = (dq_q < DQ_W'(floor_eff)) ? DQ_W'(floor_eff) : dq_q;
  assign idx_inc   = idx_q + STEP_W'(1);
  assign lvl_sat   = (dq_q > DQ_W'({LEVEL_W{1'b1}})) ? {LEVEL_W{1'b1}} :
                     dq_q[LEVEL_W-1:0];
  assign out_free  = !m_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    running_d   = running_q;
    color_d     = color_q;
    idx_d       = idx_q;
    spp_d       = spp_q;
    reps_d      = reps_q;
    lvl_d       = lvl_q;
    new_color_d = new_color_q;
    new_reps_d  = new_reps_q;
    rem_d       = rem_q;
    div_d       = div_q;
    dq_d        = dq_q;
    cnt_d       = cnt_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_data_d    = m_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          new_color_d = in_color;
          new_reps_d  = in_reps;
          if (in_cmd == lbpg_pkg::CMD_START) begin
            if (running_q && in_reps != '0) begin
              op_d    = OP_NONE;
              state_d = ST_FIN;
            end else begin
              op_d    = OP_START;
              rem_d   = '0;
              div_d   = DIVR_W'(twice);
              dq_d    = DQ_W'(ceil_num);
              cnt_d   = CNT_W'(lbpg_pkg::SQ_ITER);
              state_d = ST_DIV;
            end
          end else if (running_q) begin
            op_d    = OP_TICK;
            rem_d   = DIVR_W'(prod >> lbpg_pkg::TQ_ITER);
            div_d   = DIVR_W'(half);
            dq_d    = DQ_W'(prod[lbpg_pkg::TQ_ITER-1:0]) << (DQ_W - lbpg_pkg::TQ_ITER);
            cnt_d   = CNT_W'(lbpg_pkg::TQ_ITER);
            state_d = ST_DIV;
          end else begin
            op_d    = OP_NONE;
            state_d = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        rem_d = fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
        dq_d  = {dq_q[DQ_W-2:0], fits};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          unique case (op_q)
            OP_START: begin
              running_d = 1'b1;
              color_d   = new_color_q;
              idx_d     = '0;
              spp_d     = steps_raw[STEP_W-1:0];
              reps_d    = new_reps_q;
            end
            OP_TICK: begin
              for (int c = 0; c < 3; c++) begin
                lvl_d[c] = (color_q == COLOR_W'(c)) ? lvl_sat : '0;
              end
              idx_d = idx_inc;
              if (idx_inc >= spp_q) begin
                if (reps_q != '0) begin
                  reps_d = reps_q - REP_W'(1);
                  idx_d  = '0;
                end else begin
                  running_d = 1'b0;
                  color_d   = lbpg_pkg::COLOR_OFF;
                end
              end
            end
            default: ;
          endcase
          m_valid_d = 1'b1;
          m_data_d  = lbpg_pkg::M_TDATA_W'({(op_q == OP_START), running_d,
                                            lvl_d[2], lvl_d[1], lvl_d[0]});
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_NONE;
      running_q <= 1'b0;
      color_q   <= lbpg_pkg::COLOR_OFF;
      idx_q     <= '0;
      spp_q     <= '0;
      reps_q    <= '0;
      lvl_q[0]  <= '0;
      lvl_q[1]  <= '0;
      lvl_q[2]  <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      running_q <= running_d;
      color_q   <= color_d;
      idx_q     <= idx_d;
      spp_q     <= spp_d;
      reps_q    <= reps_d;
      lvl_q     <= lvl_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_color_q <= new_color_d;
    new_reps_q  <= new_reps_d;
    rem_q       <= rem_d;
    div_q       <= div_d;
    dq_q        <= dq_d;
    m_data_q    <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

/* rtl/core/lbpg_checker.sv */
// ----------------------------------------------------------------------------
// LED breathing pulse generator checker
// Port-level assertions on the command, result and configuration ports.
// ----------------------------------------------------------------------------
module lbpg_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             psel_i,
  input logic                             penable_i,
  input logic                             pwrite_i,
  input logic [lbpg_pkg::PADDR_W-1:0]     paddr_i,
  input logic [lbpg_pkg::PDATA_W-1:0]     pwdata_i,
  input logic [lbpg_pkg::PDATA_W-1:0]     prdata_o,
  input logic                             pready_o,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [lbpg_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  input logic                             s_axis_tuser_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [lbpg_pkg::M_TDATA_W-1:0]   m_axis_tdata_o
);

  logic red_on, green_on, blue_on, act, taken;

  assign red_on   = (m_axis_tdata_o[7:0] != '0);
  assign green_on = (m_axis_tdata_o[15:8] != '0);
  assign blue_on  = (m_axis_tdata_o[23:16] != '0);
  assign act      = m_axis_tdata_o[24];
  assign taken    = m_axis_tdata_o[25];

  // A stalled result holds its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Commands are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command taken while another was in progress");

  // A taken start always leaves a pulse running.
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && taken |-> act)
    else $error("start taken without a running pulse");

  // Only the selected channel is ever lit.
  a_one_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot0({red_on, green_on, blue_on}))
    else $error("more than one channel lit");

  // The configuration port never inserts wait states.
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_o)
    else $error("configuration port stalled");

endmodule

bind led_breathing_pulse_generator lbpg_checker u_lbpg_checker (.*);
